// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/ksf_pkg.sv -----
// Package for the keyed stack with filter: operation codes, transaction
// payload types and the controller/datapath command and status structs.
// No dependencies.
package ksf_pkg;

	localparam logic [2:0] OP_PUSH        = 3'd0;
	localparam logic [2:0] OP_FIND        = 3'd1;
	localparam logic [2:0] OP_REMOVE      = 3'd2;
	localparam logic [2:0] OP_REMOVE_EVEN = 3'd3;
	localparam logic [2:0] OP_CLEAR       = 3'd4;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic       overflow;
		logic [4:0] depth_now;
	} rsp_t;

	typedef struct packed {
		logic load_key;
		logic start_desc;
		logic start_shift;
		logic start_filter;
		logic issue;
		logic push_write;
		logic shift_step;
		logic filter_step;
		logic count_inc;
		logic count_dec;
		logic count_clear;
		logic count_from_w;
		logic set_hit;
		logic set_ovf;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic left_zero;
		logic v_s1;
		logic match;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/ksf_datapath.sv -----
// Datapath: entry memory, scan counters, read stage, depth count and the
// response register. Depends on ksf_pkg.
module ksf_datapath import ksf_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  cmd_t    cmd,
	output status_t st,
	input  logic    rsp_ready,
	output logic    rsp_valid,
	output rsp_t    rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem [DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] w_q;
	logic [IW-1:0] rd_idx_q;
	logic          dir_down_q;
	logic          hit_q;
	logic          ovf_q;
	logic [31:0]   key_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   rdata_s1;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          rd_fire;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;

	assign rd_fire = cmd.issue && (left_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = IW'(count_q);
		wr_data = key_q;
		if (cmd.push_write) begin
			wr_en = 1'b1;
		end else if (cmd.shift_step && v_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IW'(1);
			wr_data = rdata_s1;
		end else if (cmd.filter_step && v_s1 && rdata_s1[0]) begin
			wr_en   = 1'b1;
			wr_addr = IW'(w_q);
			wr_data = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_fire) begin
			rdata_s1 <= mem[rd_idx_q];
			idx_s1   <= rd_idx_q;
		end
		if (cmd.load_key) begin
			key_q <= req.value;
		end
		if (cmd.start_desc) begin
			rd_idx_q   <= IW'(count_q - CW'(1));
			dir_down_q <= 1'b1;
		end else if (cmd.start_shift) begin
			rd_idx_q   <= idx_s1 + IW'(1);
			dir_down_q <= 1'b0;
		end else if (cmd.start_filter) begin
			rd_idx_q   <= '0;
			dir_down_q <= 1'b0;
		end else if (rd_fire) begin
			rd_idx_q <= dir_down_q ? rd_idx_q - IW'(1) : rd_idx_q + IW'(1);
		end
		if (cmd.finish) begin
			out_q.hit       <= hit_q;
			out_q.overflow  <= ovf_q;
			out_q.depth_now <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			w_q         <= '0;
			v_s1        <= 1'b0;
			hit_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_fire;

			if (cmd.start_desc || cmd.start_filter) begin
				left_q <= count_q;
			end else if (cmd.start_shift) begin
				left_q <= count_q - CW'(1) - CW'(idx_s1);
			end else if (rd_fire) begin
				left_q <= left_q - CW'(1);
			end

			if (cmd.start_filter) begin
				w_q <= '0;
			end else if (cmd.filter_step && v_s1 && rdata_s1[0]) begin
				w_q <= w_q + CW'(1);
			end

			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.count_from_w) begin
				count_q <= w_q;
			end

			if (cmd.load_key) begin
				hit_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.set_hit) begin
					hit_q <= 1'b1;
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.full      = (count_q == CW'(DEPTH));
	assign st.left_zero = (left_q == '0);
	assign st.v_s1      = v_s1;
	assign st.match     = (rdata_s1 == key_q);
	assign st.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- rtl/ksf_ctrl.sv -----
// Controller state machine: sequences push, clear, search, shift-down and even
// filter scans over the datapath. Depends on ksf_pkg.
module ksf_ctrl import ksf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [2:0] operation,
	output logic       req_ready,
	input  status_t    st,
	output cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PUSH  = 7'b0000010,
		S_FIND  = 7'b0000100,
		S_RMV   = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_EVEN  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   scan_done;

	assign scan_done = st.left_zero && !st.v_s1;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_key = 1'b1;
					case (operation)
						OP_PUSH: state_d = S_PUSH;
						OP_FIND: begin
							cmd.start_desc = 1'b1;
							state_d        = S_FIND;
						end
						OP_REMOVE: begin
							cmd.start_desc = 1'b1;
							state_d        = S_RMV;
						end
						OP_REMOVE_EVEN: begin
							cmd.start_filter = 1'b1;
							state_d          = S_EVEN;
						end
						OP_CLEAR: begin
							cmd.count_clear = 1'b1;
							state_d         = S_FIN;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_PUSH: begin
				if (st.full) begin
					cmd.set_ovf = 1'b1;
				end else begin
					cmd.push_write = 1'b1;
					cmd.count_inc  = 1'b1;
				end
				state_d = S_FIN;
			end
			S_FIND: begin
				if (st.v_s1 && st.match) begin
					cmd.set_hit = 1'b1;
					state_d     = S_FIN;
				end else if (scan_done) begin
					state_d = S_FIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_RMV: begin
				if (st.v_s1 && st.match) begin
					cmd.set_hit     = 1'b1;
					cmd.start_shift = 1'b1;
					state_d         = S_SHIFT;
				end else if (scan_done) begin
					state_d = S_FIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (scan_done) begin
					cmd.count_dec = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_EVEN: begin
				cmd.filter_step = 1'b1;
				if (scan_done) begin
					cmd.count_from_w = 1'b1;
					state_d          = S_FIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/keyed_stack_with_filter_top.sv -----
// Top level of the keyed stack with filter: controller plus datapath.
// Depends on ksf_pkg, ksf_ctrl and ksf_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  req     | req_valid/req_ready  | req_t: operation, value
//  rsp     | rsp_valid/rsp_ready  | rsp_t: hit, overflow, depth_now
//
// One transaction at a time, from the accepting cycle to the cycle that
// loads the response. Push passes S_PUSH; clear and unknown codes go
// straight to S_FIN; find, remove (with a shift after a hit) and remove-even
// scan the entry memory one word a cycle, shifts writing behind.
// The next request is taken while a response still waits in its register.
// Reset clears the depth count; entry contents are left as they are.
module keyed_stack_with_filter_top import ksf_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t    cmd;
	status_t st;

	ksf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (req.operation),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ksf_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/ksf_checker.sv -----
// Port-level checker for the keyed stack with filter, bound to the top.
// Depends on ksf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ksf_checker import ksf_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`ASSERT_IMP(a_ovf_full, rsp_valid && rsp.overflow, rsp.depth_now == 5'(DEPTH))
	`ASSERT_IMP(a_flags_excl, rsp_valid, !(rsp.hit && rsp.overflow))
	`ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
	`ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind keyed_stack_with_filter_top ksf_checker #(.DEPTH(DEPTH)) u_ksf_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for keyed_stack_with_filter_top: a queue-fed driver, a monitor
// and a bit-accurate stack predictor compare every response transaction in order.
// Depends on ksf_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
	import ksf_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int TOTAL_OPS = 1150;
	localparam int CALM_TAIL = 150;
	localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
	localparam logic [2:0] OP_LAST_CODE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	keyed_stack_with_filter_top #(.DEPTH(STACK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	req_t ops_to_send[$];
	rsp_t predicted_results[$];
	logic signed [31:0] key_pool[$];

	logic signed [31:0] stack_keys [STACK_DEPTH];
	int stack_count = 0;

	int ops_queued = 0;
	int ops_taken = 0;
	int errors = 0;
	int op_hist [8];
	int hit_count = 0;
	int overflow_count = 0;
	int full_seen = 0;

	logic req_fire = 1'b0;
	logic rsp_hold = 1'b0;
	logic calm;
	int send_gap = 0;
	int recv_gap = 0;

	assign calm = (ops_to_send.size() < CALM_TAIL);

	// Predicted response for one transaction; updates the shadow stack.
	function automatic rsp_t stack_apply(req_t r);
		rsp_t res;
		int pos;
		int w;
		res = '0;
		pos = -1;
		w = 0;
		case (r.operation)
			OP_PUSH: begin
				if (stack_count >= STACK_DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					stack_keys[stack_count] = r.value;
					stack_count++;
				end
			end
			OP_FIND, OP_REMOVE: begin
				for (int i = stack_count - 1; i >= 0 && pos < 0; i--)
					if (stack_keys[i] == r.value)
						pos = i;
				if (pos >= 0) begin
					res.hit = 1'b1;
					if (r.operation == OP_REMOVE) begin
						for (int i = pos; i + 1 < stack_count; i++)
							stack_keys[i] = stack_keys[i + 1];
						stack_count--;
					end
				end
			end
			OP_REMOVE_EVEN: begin
				for (int i = 0; i < stack_count; i++) begin
					if (stack_keys[i][0]) begin
						stack_keys[w] = stack_keys[i];
						w++;
					end
				end
				stack_count = w;
			end
			OP_CLEAR: begin
				stack_count = 0;
			end
			default: begin
			end
		endcase
		res.depth_now = 5'(stack_count);
		return res;
	endfunction

	task automatic queue_op(logic [2:0] op, logic signed [31:0] key);
		req_t r;
		r.operation = op;
		r.value = key;
		ops_to_send.push_back(r);
		ops_queued++;
		if (op == OP_PUSH) begin
			key_pool.push_back(key);
			if (key_pool.size() > 32)
				void'(key_pool.pop_front());
		end
	endtask

	// Mostly keys already pushed, so find and remove hit often.
	function automatic logic signed [31:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if ($urandom_range(0, 1) == 0)
			return 32'($signed($urandom_range(0, 15)) - 8);
		return $urandom;
	endfunction

	// Driver: one transaction per handshake, random idle bursts until the tail.
	always @(negedge clk) begin : drive_req
		logic next_valid;
		req_t next_req;
		next_valid = req_valid;
		next_req = req;
		if (arst_n && (!req_valid || req_fire)) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (ops_to_send.size() > 0) begin
				if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 10) - 1;
				end else begin
					next_req = ops_to_send.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		req_valid <= next_valid;
		req <= next_req;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_hold) begin
				rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 10) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on request transaction, check on response transaction.
	always @(posedge clk) begin : monitor
		rsp_t exp_rsp;
		req_fire <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				op_hist[req.operation]++;
				if (req.operation == OP_PUSH && stack_count == STACK_DEPTH)
					full_seen++;
				predicted_results.push_back(stack_apply(req));
				ops_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				if (predicted_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected response, expected none, actual %b/%b/%0d",
						$time, rsp.hit, rsp.overflow, rsp.depth_now);
				end else begin
					exp_rsp = predicted_results.pop_front();
					hit_count += exp_rsp.hit;
					overflow_count += exp_rsp.overflow;
					if (exp_rsp.hit !== rsp.hit || exp_rsp.overflow !== rsp.overflow
						|| exp_rsp.depth_now !== rsp.depth_now) begin
						errors++;
						$display("%0t: mismatch expected %b/%b/%0d actual %b/%b/%0d",
							$time, exp_rsp.hit, exp_rsp.overflow, exp_rsp.depth_now,
							rsp.hit, rsp.overflow, rsp.depth_now);
					end
				end
			end
		end
	end

	// Long receiver stall so the block backs up and drops req_ready.
	initial begin
		while (ops_taken < 300)
			@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Timeout: %0d of %0d transactions taken", ops_taken, ops_queued);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int kind;
		int n;
		logic [2:0] op;

		for (int i = 0; i < 8; i++)
			op_hist[i] = 0;

		// directed: empty stack, extremes, duplicates, negative even keys, unused codes
		queue_op(OP_FIND, 32'sd5);
		queue_op(OP_REMOVE, 32'sd5);
		queue_op(OP_REMOVE_EVEN, 32'sd0);
		queue_op(OP_PUSH, 32'sh7FFF_FFFF);
		queue_op(OP_PUSH, 32'sh8000_0000);
		queue_op(OP_PUSH, 32'sd0);
		queue_op(OP_PUSH, -32'sd1);
		queue_op(OP_PUSH, -32'sd4);
		queue_op(OP_PUSH, -32'sd4);
		queue_op(OP_PUSH, 32'sd6);
		queue_op(OP_PUSH, -32'sd3);
		queue_op(OP_FIND, -32'sd4);
		queue_op(OP_FIND, 32'sd12345);
		queue_op(OP_REMOVE, 32'sd99);
		queue_op(OP_REMOVE, -32'sd4);
		for (logic [3:0] c = 4'(OP_CLEAR) + 4'd1; c <= OP_LAST_CODE; c++)
			queue_op(c[2:0], $urandom);
		queue_op(OP_REMOVE_EVEN, $urandom);
		queue_op(OP_FIND, 32'sd0);
		queue_op(OP_REMOVE_EVEN, $urandom);
		queue_op(OP_CLEAR, $urandom);
		queue_op(OP_FIND, -32'sd1);

		// fill past full first, then random sequences
		for (int i = 0; i < STACK_DEPTH + 3; i++)
			queue_op(OP_PUSH, pick_key());
		while (ops_queued < TOTAL_OPS) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					queue_op(OP_PUSH, pick_key());
			end else if (kind <= 6) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					queue_op($urandom_range(0, 1) ? OP_FIND : OP_REMOVE, pick_key());
			end else if (kind == 7) begin
				queue_op(OP_REMOVE_EVEN, $urandom);
			end else if (kind == 8) begin
				if ($urandom_range(0, 2) == 0)
					queue_op(3'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE)), $urandom);
				else
					queue_op(OP_CLEAR, $urandom);
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					op = 3'($urandom_range(0, OP_LAST_CODE));
					queue_op(op, $urandom);
				end
			end
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (ops_taken < ops_queued)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d taken: push %0d find %0d remove %0d even %0d clear %0d other %0d",
			ops_taken, op_hist[OP_PUSH], op_hist[OP_FIND], op_hist[OP_REMOVE],
			op_hist[OP_REMOVE_EVEN], op_hist[OP_CLEAR],
			ops_taken - op_hist[OP_PUSH] - op_hist[OP_FIND] - op_hist[OP_REMOVE]
			- op_hist[OP_REMOVE_EVEN] - op_hist[OP_CLEAR]);
		$display("Hits %0d, overflows %0d (pushes onto a full stack %0d), mismatches %0d",
			hit_count, overflow_count, full_seen, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
